// ===== sv/u8d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and the Windows-1252 high-control map for the UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int MaxUnits = 4;

  // Windows-1252 code points for bytes 80-9F
  localparam logic [15:0] CP1252_C1 [32] = '{
    16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
    16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
  };

  // results produced by one input byte
  typedef struct packed {
    logic [2:0]                    cnt;
    logic [MaxUnits-1:0][15:0]     units;
    logic [MaxUnits-1:0]           subs;
  } u8d_batch_t;

  // map a raw byte through the Windows-1252 table
  function automatic logic [15:0] map_1252(input logic [7:0] b);
    logic [15:0] r;
    if (b[7:5] == 3'b100) begin
      r = CP1252_C1[b[4:0]];
    end else begin
      r = {8'h00, b};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/u8d_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_if
// Valid/ready channels: raw bytes in, UTF-16 code units out.
// ----------------------------------------------------------------------------
interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8d_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        substituted;
  logic        last;

  modport source (output valid, output code_unit, output substituted, output last,
                  input ready);
  modport sink   (input valid, input code_unit, input substituted, input last,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/u8d_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_scan
// Scans held bytes plus the new byte, emits decoded units and the new hold.
// ----------------------------------------------------------------------------
module u8d_scan (
  input  wire logic [2:0][7:0]      held,
  input  wire logic [1:0]           held_count,
  input  wire logic [7:0]           in_byte,
  output u8d_pkg::u8d_batch_t       batch,
  output logic [2:0][7:0]           held_next,
  output logic [1:0]                held_count_next
);
  import u8d_pkg::*;

  typedef struct packed {
    logic        hold;
    logic [2:0]  adv;
    logic        two;
    logic        sub;
    logic [15:0] u0;
    logic [15:0] u1;
  } step_t;

  // decode one sequence start given the bytes available from there
  function automatic step_t decode_step(input logic [7:0] h, input logic [7:0] c1,
                                        input logic [7:0] c2, input logic [7:0] c3,
                                        input logic [2:0] avail);
    step_t      r;
    logic [2:0] len;
    logic       ok;
    logic [20:0] cp;
    logic [20:0] minv;
    logic [20:0] adj;
    r = '0;
    r.adv = 3'd1;
    len = 3'd0;
    cp = '0;
    minv = '0;
    if (h[7] == 1'b0) begin
      r.u0 = {8'h00, h};
    end else begin
      // lead byte classes
      if (h >= 8'hC2 && h <= 8'hDF) begin
        len = 3'd2;
        cp = {10'd0, h[4:0], c1[5:0]};
        minv = 21'h000080;
      end else if (h >= 8'hE0 && h <= 8'hEF) begin
        len = 3'd3;
        cp = {5'd0, h[3:0], c1[5:0], c2[5:0]};
        minv = 21'h000800;
      end else if (h >= 8'hF0 && h <= 8'hF4) begin
        len = 3'd4;
        cp = {h[2:0], c1[5:0], c2[5:0], c3[5:0]};
        minv = 21'h010000;
      end
      r.u0 = map_1252(h);
      r.sub = 1'b1;
      if (len != 3'd0) begin
        if (len > avail) begin
          r.hold = 1'b1;
        end else begin
          ok = (c1[7:6] == 2'b10) &&
               (len < 3'd3 || c2[7:6] == 2'b10) &&
               (len < 3'd4 || c3[7:6] == 2'b10);
          if (ok && cp >= minv && cp <= 21'h10FFFF &&
              !(cp >= 21'h00D800 && cp <= 21'h00DFFF)) begin
            r.sub = 1'b0;
            r.adv = len;
            adj = cp - 21'h010000;
            if (cp[20:16] == 5'd0) begin
              r.u0 = cp[15:0];
            end else begin
              r.two = 1'b1;
              r.u0 = {6'b110110, adj[19:10]};
              r.u1 = {6'b110111, adj[9:0]};
            end
          end
        end
      end
    end
    return r;
  endfunction

  // up to four sequence starts, each consumes at least one byte
  always_comb begin
    logic [6:0][7:0] b;
    logic [2:0]      n;
    logic [2:0]      i;
    logic [2:0]      avail;
    logic            done;
    step_t           st;
    b = '0;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < held_count) begin
        b[k] = held[k];
      end
    end
    b[{1'b0, held_count}] = in_byte;
    n = {1'b0, held_count} + 3'd1;
    i = '0;
    done = 1'b0;
    avail = '0;
    st = '0;
    batch = '0;
    held_next = '0;
    held_count_next = '0;
    for (int s = 0; s < 4; s++) begin
      if (!done && i < n) begin
        avail = n - i;
        st = decode_step(b[i], b[i + 3'd1], b[i + 3'd2], b[i + 3'd3], avail);
        if (st.hold) begin
          for (int k = 0; k < 3; k++) begin
            if (3'(k) < avail) begin
              held_next[k] = b[i + 3'(k)];
            end
          end
          held_count_next = avail[1:0];
          done = 1'b1;
        end else begin
          if (batch.cnt < 3'd4) begin
            batch.units[batch.cnt[1:0]] = st.u0;
            batch.subs[batch.cnt[1:0]] = st.sub;
            batch.cnt = batch.cnt + 3'd1;
          end
          if (st.two && batch.cnt < 3'd4) begin
            batch.units[batch.cnt[1:0]] = st.u1;
            batch.subs[batch.cnt[1:0]] = 1'b0;
            batch.cnt = batch.cnt + 3'd1;
          end
          i = i + st.adv;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/u8d_out_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_out_queue
// Result register holding one byte's units, drained one beat per cycle while units.ready is high.
// ----------------------------------------------------------------------------
module u8d_out_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire u8d_pkg::u8d_batch_t  batch,
  output logic                      can_load,
  u8d_unit_if.source                units
);
  import u8d_pkg::*;

  logic                       q_valid;
  logic [1:0]                 q_ptr;
  logic [1:0]                 q_last;
  logic [MaxUnits-1:0][15:0]  q_units;
  logic [MaxUnits-1:0]        q_subs;
  logic                       at_last;
  logic                       out_beat;

  assign at_last  = (q_ptr == q_last);
  assign out_beat = units.valid && units.ready;
  assign can_load = !q_valid || (units.ready && at_last);

  // output beat comes straight from the result register
  assign units.valid       = q_valid;
  assign units.code_unit   = q_units[q_ptr];
  assign units.substituted = q_subs[q_ptr];
  assign units.last        = at_last;

  // reload from a newly accepted byte, else drain
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
      q_ptr   <= '0;
      q_last  <= '0;
    end else begin
      if (load && batch.cnt != 3'd0) begin
        q_valid <= 1'b1;
        q_ptr   <= '0;
        q_last  <= 2'(batch.cnt - 3'd1);
      end else if (out_beat) begin
        if (at_last) begin
          q_valid <= 1'b0;
        end else begin
          q_ptr <= q_ptr + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_units <= batch.units;
      q_subs  <= batch.subs;
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !q_valid)
    else $error("result register not empty after reset");
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> q_ptr <= q_last)
    else $error("read pointer past last unit");
  a_load_start: assert property (@(posedge clk) disable iff (rst)
    (load && batch.cnt != 3'd0) |=> (q_valid && q_ptr == 2'd0))
    else $error("new batch not presented from its first unit");
  a_step: assert property (@(posedge clk) disable iff (rst)
    (out_beat && !at_last) |=> (q_valid && q_ptr == $past(q_ptr) + 2'd1))
    else $error("drain skipped or repeated a unit");
  a_load_only_free: assert property (@(posedge clk) disable iff (rst)
    (load && q_valid) |-> (out_beat && at_last))
    else $error("batch loaded over undelivered units");
`endif

endmodule
`default_nettype wire

// ===== sv/utf8_decoder_cp1252_fallback.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_decoder_cp1252_fallback
// UTF-8 to UTF-16 decoder with a Windows-1252 fallback for undecodable bytes.
// ----------------------------------------------------------------------------
// One byte is accepted per beat on byte_chan and its results appear on
// unit_chan from the next cycle, one code unit per cycle while unit_chan is
// ready. A byte that yields one unit (or none, while a sequence is still
// open) lets the next byte in on the following cycle when unit_chan does not
// stall, so plain text runs at one byte per clock. A byte that yields k units
// (a surrogate pair, or a lead byte flushed with the bytes held behind it)
// occupies the single result register until its last unit, with which the
// next byte is taken. Held bytes of an open sequence and the result register
// are the only state; held plus new bytes are scanned in the accepting cycle.
// ----------------------------------------------------------------------------
module utf8_decoder_cp1252_fallback (
  input  wire logic   clk,
  input  wire logic   rst,
  u8d_byte_if.sink    byte_chan,
  u8d_unit_if.source  unit_chan
);
  import u8d_pkg::*;

  logic [2:0][7:0] held;
  logic [1:0]      held_count;
  logic [2:0][7:0] held_next;
  logic [1:0]      held_count_next;
  u8d_batch_t      batch;
  logic            can_load;
  logic            accept;

  assign byte_chan.ready = can_load;
  assign accept = byte_chan.valid && can_load;

  u8d_scan u_scan (
    .held            (held),
    .held_count      (held_count),
    .in_byte         (byte_chan.in_byte),
    .batch           (batch),
    .held_next       (held_next),
    .held_count_next (held_count_next)
  );

  u8d_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .batch    (batch),
    .can_load (can_load),
    .units    (unit_chan)
  );

  // bytes of an open sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= '0;
      held_count <= '0;
    end else if (accept) begin
      held       <= held_next;
      held_count <= held_count_next;
    end
  end

endmodule
`default_nettype wire
